FILE: src/rmea_pkg.sv
// ----------------------------------------------------------------------------
// rmea_pkg
// Shared types, constants and arctangent table for the rotation matrix to
// Euler angle converter.
// ----------------------------------------------------------------------------
package rmea_pkg;

   localparam int CORDIC_STEPS        = 14;
   localparam int ANGLE_FRACTION_BITS = 13;
   localparam int DW                  = 36;   // CORDIC x/y, Q28 plus growth
   localparam int ZW                  = 34;   // angle accumulator, Q30
   localparam int SQ_STEPS            = 29;   // root bits of a 57-bit radicand
   localparam int VW                  = 58;
   localparam int DBITS               = 29;
   localparam int OUT_SHIFT           = 30 - ANGLE_FRACTION_BITS;
   localparam int LOCK_THRESHOLD      = 16382;
   localparam int ONE_Q14             = 16384;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   localparam logic signed [16:0] PI_OUT =
      17'((PI_Q30 + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT);
   localparam logic signed [16:0] HALF_PI_OUT =
      17'((HALF_PI_Q30 + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT);

   typedef logic signed [DW-1:0] data_type;
   typedef logic signed [ZW-1:0] angle_type;

   typedef struct packed {
      logic lock;
      logic sat_pos;
      logic sat_neg;
   } flag_type;

   typedef struct packed {
      data_type h_y;
      data_type h_x;
      data_type b_y;
      data_type b_x;
      data_type p_y;
      flag_type flags;
   } side_type;

   // atan(2^-i) in Q30, truncated
   function automatic angle_type atan_entry(input int idx);
      angle_type r;
      case (idx)
         0:  r = ZW'(843314856);
         1:  r = ZW'(497837829);
         2:  r = ZW'(263043836);
         3:  r = ZW'(133525158);
         4:  r = ZW'(67021686);
         5:  r = ZW'(33543515);
         6:  r = ZW'(16775850);
         7:  r = ZW'(8388437);
         8:  r = ZW'(4194282);
         9:  r = ZW'(2097149);
         10: r = ZW'(1048575);
         11: r = ZW'(524287);
         12: r = ZW'(262143);
         13: r = ZW'(131071);
         14: r = ZW'(65535);
         15: r = ZW'(32767);
         16: r = ZW'(16383);
         17: r = ZW'(8191);
         18: r = ZW'(4095);
         19: r = ZW'(2047);
         20: r = ZW'(1023);
         21: r = ZW'(511);
         22: r = ZW'(255);
         23: r = ZW'(127);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q2.14 element to Q28
   function automatic data_type scale_elem(input logic signed [16:0] v);
      data_type t;
      t = {{(DW-17){v[16]}}, v};
      return t <<< 14;
   endfunction

   // Q30 to output format, round half up, then clamp to +-lim
   function automatic logic signed [16:0] round_clamp(input angle_type z,
                                                      input logic signed [16:0] lim);
      angle_type r;
      angle_type l;
      r = (z + (ZW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      l = {{(ZW-17){lim[16]}}, lim};
      if (r > l) begin
         r = l;
      end else if (r < -l) begin
         r = -l;
      end
      return r[16:0];
   endfunction

endpackage

FILE: src/rmea_sqrt.sv
// ----------------------------------------------------------------------------
// rmea_sqrt
// Pipelined integer square root, one root bit per stage, carrying the item's
// side data alongside.
// ----------------------------------------------------------------------------
module rmea_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  rmea_pkg::side_type              in_side,
   input  logic [rmea_pkg::DBITS-1:0]      in_d,
   output logic                            out_valid,
   output rmea_pkg::side_type              out_side,
   output logic [rmea_pkg::DBITS-1:0]      out_root
);

   logic                       valid_ff [rmea_pkg::SQ_STEPS];
   rmea_pkg::side_type         side_ff  [rmea_pkg::SQ_STEPS];
   logic [rmea_pkg::VW-1:0]    v_ff     [rmea_pkg::SQ_STEPS];
   logic [rmea_pkg::VW-1:0]    res_ff   [rmea_pkg::SQ_STEPS];

   for (genvar k = 0; k < rmea_pkg::SQ_STEPS; k++) begin : g_stage
      localparam logic [rmea_pkg::VW-1:0] BIT =
         rmea_pkg::VW'(1) << (2 * (rmea_pkg::SQ_STEPS - 1 - k));
      logic                    src_valid;
      rmea_pkg::side_type      src_side;
      logic [rmea_pkg::VW-1:0] src_v;
      logic [rmea_pkg::VW-1:0] src_res;
      logic [rmea_pkg::VW-1:0] trial;
      logic [rmea_pkg::VW-1:0] v_in;
      logic [rmea_pkg::VW-1:0] res_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_side  = in_side;
         assign src_v     = {1'b0, in_d, 28'b0};
         assign src_res   = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_side  = side_ff[k-1];
         assign src_v     = v_ff[k-1];
         assign src_res   = res_ff[k-1];
      end

      always_comb begin
         trial = src_res + BIT;
         if (src_v >= trial) begin
            v_in   = src_v - trial;
            res_in = (src_res >> 1) + BIT;
         end else begin
            v_in   = src_v;
            res_in = src_res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid;
         end
         if (advance) begin
            side_ff[k] <= src_side;
            v_ff[k]    <= v_in;
            res_ff[k]  <= res_in;
         end
      end
   end

   assign out_valid = valid_ff[rmea_pkg::SQ_STEPS-1];
   assign out_side  = side_ff[rmea_pkg::SQ_STEPS-1];
   assign out_root  = res_ff[rmea_pkg::SQ_STEPS-1][rmea_pkg::DBITS-1:0];

endmodule

FILE: src/rmea_cordic.sv
// ----------------------------------------------------------------------------
// rmea_cordic
// Pipelined four-quadrant arctangent: quadrant pre-rotation stage followed by
// one vectoring CORDIC iteration per stage. Angle out in Q30.
// ----------------------------------------------------------------------------
module rmea_cordic (
   input  logic                  clock,
   input  logic                  advance,
   input  rmea_pkg::data_type    x_in,
   input  rmea_pkg::data_type    y_in,
   output rmea_pkg::angle_type   z_out
);

   localparam int N = rmea_pkg::CORDIC_STEPS + 1;

   rmea_pkg::data_type  x_ff    [N];
   rmea_pkg::data_type  y_ff    [N];
   rmea_pkg::angle_type z_ff    [N];
   logic                zero_ff [N];

   rmea_pkg::data_type  x_pre;
   rmea_pkg::data_type  y_pre;
   rmea_pkg::angle_type z_pre;

   always_comb begin
      x_pre = x_in;
      y_pre = y_in;
      z_pre = '0;
      if (x_in < 0) begin
         if (y_in >= 0) begin
            x_pre = y_in;
            y_pre = -x_in;
            z_pre = rmea_pkg::ZW'(rmea_pkg::HALF_PI_Q30);
         end else begin
            x_pre = -y_in;
            y_pre = x_in;
            z_pre = -rmea_pkg::ZW'(rmea_pkg::HALF_PI_Q30);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x_pre;
         y_ff[0]    <= y_pre;
         z_ff[0]    <= z_pre;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
      end
   end

   for (genvar k = 0; k < rmea_pkg::CORDIC_STEPS; k++) begin : g_iter
      localparam rmea_pkg::angle_type ATAN = rmea_pkg::atan_entry(k);
      rmea_pkg::data_type  dx;
      rmea_pkg::data_type  dy;
      rmea_pkg::data_type  x_in_k;
      rmea_pkg::data_type  y_in_k;
      rmea_pkg::angle_type z_in_k;

      always_comb begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         if (y_ff[k] >= 0) begin
            x_in_k = x_ff[k] + dx;
            y_in_k = y_ff[k] - dy;
            z_in_k = z_ff[k] + ATAN;
         end else begin
            x_in_k = x_ff[k] - dx;
            y_in_k = y_ff[k] + dy;
            z_in_k = z_ff[k] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k+1]    <= x_in_k;
            y_ff[k+1]    <= y_in_k;
            z_ff[k+1]    <= z_in_k;
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   assign z_out = zero_ff[N-1] ? '0 : z_ff[N-1];

endmodule

FILE: src/rotation_matrix_to_euler_angles.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles
// Converts seven elements of a Q2.14 rotation matrix to heading and bank in
// Q3.13 and pitch in Q2.13 radians, with a gimbal lock flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one matrix item; accepted when req_valid is high and
//   req_stall low. rsp_* carries one angle item per matrix, accepted when
//   rsp_valid is high and rsp_stall low.
//   Pipeline: one input register, 29 square-root stages (one root bit each),
//   one quadrant stage plus CORDIC_STEPS arctangent stages (three CORDICs in
//   parallel), and one output register: 46 register stages.
//   Throughput is one item per cycle while the output is not stalled; every stage is one register deep.
//   Reset clears every valid bit; no item is in flight afterwards.
//   While rsp_valid is high and rsp_stall high, the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_r11,
   input  logic signed [15:0] req_r12,
   input  logic signed [15:0] req_r13,
   input  logic signed [15:0] req_r22,
   input  logic signed [15:0] req_r31,
   input  logic signed [15:0] req_r32,
   input  logic signed [15:0] req_r33,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_heading_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_bank_angle,
   output logic               rsp_gimbal_lock
);

   localparam int N = rmea_pkg::CORDIC_STEPS + 1;

   logic advance;

   logic                            s0_valid_ff;
   rmea_pkg::side_type              s0_side_ff;
   logic [rmea_pkg::DBITS-1:0]      s0_d_ff;

   rmea_pkg::side_type              side_in;
   logic [rmea_pkg::DBITS-1:0]      d_in;
   logic signed [16:0]              sp;
   logic signed [15:0]              sp_mid;
   logic [31:0]                     sq;

   logic                            sq_valid;
   rmea_pkg::side_type              sq_side;
   logic [rmea_pkg::DBITS-1:0]      sq_root;

   rmea_pkg::angle_type             zh;
   rmea_pkg::angle_type             zb;
   rmea_pkg::angle_type             zp;

   logic                            vl_ff [N];
   rmea_pkg::flag_type              fl_ff [N];

   logic                            rsp_valid_ff;
   logic signed [15:0]              heading_ff;
   logic signed [14:0]              pitch_ff;
   logic signed [15:0]              bank_ff;
   logic                            lock_ff;

   logic signed [16:0]              heading_in;
   logic signed [16:0]              pitch_in;
   logic signed [16:0]              bank_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      sp                   = -{req_r32[15], req_r32};
      side_in.flags.sat_pos = sp >= 17'sd16384;
      side_in.flags.sat_neg = sp <= -17'sd16384;
      side_in.flags.lock    = (sp > 17'(rmea_pkg::LOCK_THRESHOLD)) ||
                              (sp < -17'(rmea_pkg::LOCK_THRESHOLD));
      sp_mid = (side_in.flags.sat_pos || side_in.flags.sat_neg) ? 16'sd0 : sp[15:0];
      sq     = 32'(sp_mid) * 32'(sp_mid);
      d_in   = rmea_pkg::DBITS'(33'(rmea_pkg::ONE_Q14) * 33'(rmea_pkg::ONE_Q14) -
                                {1'b0, sq});
      side_in.p_y = rmea_pkg::scale_elem({sp_mid[15], sp_mid});
      if (side_in.flags.lock) begin
         side_in.h_y = rmea_pkg::scale_elem(-{req_r13[15], req_r13});
         side_in.h_x = rmea_pkg::scale_elem({req_r11[15], req_r11});
      end else begin
         side_in.h_y = rmea_pkg::scale_elem({req_r31[15], req_r31});
         side_in.h_x = rmea_pkg::scale_elem({req_r33[15], req_r33});
      end
      side_in.b_y = rmea_pkg::scale_elem({req_r12[15], req_r12});
      side_in.b_x = rmea_pkg::scale_elem({req_r22[15], req_r22});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
      if (advance) begin
         s0_side_ff <= side_in;
         s0_d_ff    <= d_in;
      end
   end

   rmea_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_side   (s0_side_ff),
      .in_d      (s0_d_ff),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   rmea_cordic u_heading (
      .clock   (clock),
      .advance (advance),
      .x_in    (sq_side.h_x),
      .y_in    (sq_side.h_y),
      .z_out   (zh)
   );

   rmea_cordic u_bank (
      .clock   (clock),
      .advance (advance),
      .x_in    (sq_side.b_x),
      .y_in    (sq_side.b_y),
      .z_out   (zb)
   );

   rmea_cordic u_pitch (
      .clock   (clock),
      .advance (advance),
      .x_in    ({{(rmea_pkg::DW-rmea_pkg::DBITS){1'b0}}, sq_root}),
      .y_in    (sq_side.p_y),
      .z_out   (zp)
   );

   for (genvar k = 0; k < N; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (reset) begin
            vl_ff[k] <= 1'b0;
         end else if (advance) begin
            vl_ff[k] <= (k == 0) ? sq_valid : vl_ff[(k == 0) ? 0 : k-1];
         end
         if (advance) begin
            fl_ff[k] <= (k == 0) ? sq_side.flags : fl_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_comb begin
      heading_in = rmea_pkg::round_clamp(zh, rmea_pkg::PI_OUT);
      if (fl_ff[N-1].sat_pos) begin
         pitch_in = rmea_pkg::HALF_PI_OUT;
      end else if (fl_ff[N-1].sat_neg) begin
         pitch_in = -rmea_pkg::HALF_PI_OUT;
      end else begin
         pitch_in = rmea_pkg::round_clamp(zp, rmea_pkg::HALF_PI_OUT);
      end
      bank_in = fl_ff[N-1].lock ? 17'sd0 : rmea_pkg::round_clamp(zb, rmea_pkg::PI_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vl_ff[N-1];
      end
      if (advance) begin
         heading_ff <= heading_in[15:0];
         pitch_ff   <= pitch_in[14:0];
         bank_ff    <= bank_in[15:0];
         lock_ff    <= fl_ff[N-1].lock;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_angle = heading_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_bank_angle    = bank_ff;
   assign rsp_gimbal_lock   = lock_ff;

`ifndef SYNTH
   a_lock_bank_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_lock |-> rsp_bank_angle == 16'sd0)
      else $error("bank not zero in gimbal lock");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'(rmea_pkg::HALF_PI_OUT)) &&
                    (rsp_pitch_angle >= -15'(rmea_pkg::HALF_PI_OUT)))
      else $error("pitch out of range");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
